// ----- hdl/odo_pkg.sv -----
`default_nettype none
package odo_pkg;
  localparam int DIST_W     = 34;  // squared distance fields and eps_sq
  localparam int MINPTS_W   = 7;
  localparam int NDIMS_W    = 3;
  localparam int IDX_W      = 6;   // point_index field
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 34;
  localparam int STAMP_W    = 12;

  localparam logic [CFG_IDX_W-1:0] REG_EPS_SQ     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 2'd2;
endpackage
`default_nettype wire

// ----- hdl/odo_if.sv -----
`default_nettype none
interface odo_in_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] coord;
  logic                          end_of_set;
  modport source (output valid, coord, end_of_set, input ready);
  modport sink   (input valid, coord, end_of_set, output ready);
endinterface

interface odo_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  point_index;
  logic [33:0] core_dist_sq;
  logic        core_finite;
  logic [33:0] reach_dist_sq;
  logic        reach_finite;
  logic        points_dropped;
  logic        last;
  modport source (output valid, point_index, core_dist_sq, core_finite, reach_dist_sq,
                  reach_finite, points_dropped, last, input ready);
  modport sink   (input valid, point_index, core_dist_sq, core_finite, reach_dist_sq,
                  reach_finite, points_dropped, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/odo_dist.sv -----
`default_nettype none
// Squared Euclidean distance, one dimension per step through one multiplier.
module odo_dist #(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_DIMS    = 4,
  parameter int DW          = 35
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [$clog2(MAX_DIMS+1)-1:0]       dims,
  input  wire logic [MAX_DIMS*COORD_WIDTH-1:0]     a_row,
  input  wire logic [MAX_DIMS*COORD_WIDTH-1:0]     b_row,
  output logic                                     done,
  output logic [DW-1:0]                            dist_sq
);
  localparam int DCW = $clog2(MAX_DIMS+1);
  localparam int RW  = MAX_DIMS*COORD_WIDTH;

  logic                        busy, pv;
  logic [DCW-1:0]              d;
  logic [RW-1:0]               a_q, b_q;
  logic [DCW-1:0]              dims_q;
  logic [2*COORD_WIDTH-1:0]    prod;
  logic [DW-1:0]               acc;
  logic signed [COORD_WIDTH-1:0] ca, cb;
  logic signed [COORD_WIDTH:0]   diff;
  logic signed [2*COORD_WIDTH+1:0] sq;

  always_comb begin
    ca = '0;
    cb = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (d == DCW'(i)) begin
        ca = a_q[i*COORD_WIDTH +: COORD_WIDTH];
        cb = b_q[i*COORD_WIDTH +: COORD_WIDTH];
      end
    end
    diff = (COORD_WIDTH+1)'(ca) - (COORD_WIDTH+1)'(cb);
    sq   = diff * diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
      d    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        pv     <= 1'b0;
        d      <= '0;
        acc    <= '0;
        a_q    <= a_row;
        b_q    <= b_row;
        dims_q <= dims;
      end else if (busy) begin
        pv <= (d < dims_q);
        if (d < dims_q) begin
          prod <= sq[2*COORD_WIDTH-1:0];
          d    <= d + 1'b1;
        end
        if (pv) acc <= acc + DW'(prod);
        if (d == dims_q && !pv) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign dist_sq = acc;
endmodule
`default_nettype wire

// ----- hdl/optics_density_ordering.sv -----
`default_nettype none
// Channel  | Dir | Payload                                     | Handshake
// in_ch    | in  | coord, end_of_set                           | valid/ready
// out_ch   | out | point_index, core/reach dist + finite flags,| valid/ready
//          |     | points_dropped, last                        |
// cfg      | in  | cfg_index, cfg_data                         | cfg_we
//
// Loading: one coordinate word per cycle into the row store.
// Clustering after the end word is paced by the shared distance unit and the
// single-port sweeps over the N stored points of D dims.
// in_ch.ready is low from an end word that closes a non-empty set until the last result word is taken.
// Results wait in an output register while out_ch.ready is low.
// rst is synchronous; point, neighbor and order stores need no clearing.
module optics_density_ordering #(
  parameter int MAX_POINTS  = 64,
  parameter int MAX_DIMS    = 4,
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [odo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [odo_pkg::CFG_DATA_W-1:0]    cfg_data,
  odo_in_if.sink                                 in_ch,
  odo_out_if.source                              out_ch
);
  import odo_pkg::*;

  localparam int PIW = $clog2(MAX_POINTS);
  localparam int PCW = $clog2(MAX_POINTS+1);
  localparam int DCW = $clog2(MAX_DIMS+1);
  localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int RW  = MAX_DIMS*COORD_WIDTH;
  localparam int DW0 = 2*COORD_WIDTH + DCW;
  localparam int DW  = (DW0 > DIST_W) ? DW0 : DIST_W;

  localparam logic [3:0] S_LOAD  = 4'd0,  S_OUTER = 4'd1,  S_PROC  = 4'd2,
                         S_PROW  = 4'd3,  S_DRD   = 4'd4,  S_DRD2  = 4'd5,
                         S_DWAIT = 4'd6,  S_CORE  = 4'd7,  S_KSEL  = 4'd8,
                         S_UPD   = 4'd9,  S_SEED  = 4'd10, S_E0    = 4'd11,
                         S_E1    = 4'd12, S_E2    = 4'd13, S_E3    = 4'd14,
                         S_E4    = 4'd15;

  // configuration
  logic [DIST_W-1:0]   eps_sq;
  logic [MINPTS_W-1:0] min_points;
  logic [NDIMS_W-1:0]  num_dims;

  logic [3:0]     state;
  logic [PCW-1:0] point_count, outer, idx, order_len, nb_cnt, acc, bcnt, k;
  logic [DIW-1:0] coord_counter;
  logic           dropped, ph, have_cur, found;
  logic [PIW-1:0] p, bidx, ep;
  logic [RW-1:0]  row_buf, prow;
  logic [MAX_POINTS-1:0] processed, rset, nb;
  logic [STAMP_W-1:0] stamp, bs;
  logic [DW-1:0]  cur, best, core_val, br;

  // memories
  logic [RW-1:0]      row_mem   [MAX_POINTS];
  logic [DW-1:0]      dist_mem  [MAX_POINTS];
  logic [DW-1:0]      reach_mem [MAX_POINTS];
  logic [STAMP_W-1:0] stamp_mem [MAX_POINTS];
  logic [DW:0]        core_mem  [MAX_POINTS];
  logic [PIW-1:0]     order_mem [MAX_POINTS];
  logic [RW-1:0]      row_rd;
  logic [DW-1:0]      dist_rd, reach_rd;
  logic [STAMP_W-1:0] stamp_rd;
  logic [DW:0]        core_rd;
  logic [PIW-1:0]     order_rd;

  // derived control
  logic [DCW-1:0]      dims_c;
  logic [DIW-1:0]      cc_eff;
  logic [MINPTS_W-1:0] need;
  logic [RW-1:0]       row_next;
  logic                in_acc, last_coord;
  logic [PCW-1:0]      pc_next;
  logic [PIW-1:0]      row_ra, reach_ra;
  logic                core_we;
  logic [DW:0]         core_wd;
  logic [PCW-1:0]      acc_sum;
  logic [DW-1:0]       nr;
  logic                dist_start, dist_done;
  logic [DW-1:0]       dist_val;

  assign in_ch.ready = (state == S_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (num_dims == '0)               dims_c = DCW'(1);
    else if (int'(num_dims) > MAX_DIMS) dims_c = DCW'(MAX_DIMS);
    else                              dims_c = DCW'(num_dims);
    cc_eff = (int'(coord_counter) >= int'(dims_c)) ? '0 : coord_counter;
    row_next = (cc_eff == '0) ? '0 : row_buf;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (cc_eff == DIW'(i)) row_next[i*COORD_WIDTH +: COORD_WIDTH] = in_ch.coord;
    end
    last_coord = (int'(cc_eff) + 1 >= int'(dims_c));
    pc_next = (last_coord && int'(point_count) < MAX_POINTS) ? point_count + 1'b1
                                                             : point_count;
    need = ((min_points < MINPTS_W'(2)) ? MINPTS_W'(2) : min_points) - 1'b1;
    acc_sum = acc + bcnt;
    nr = (dist_rd > core_val) ? dist_rd : core_val;
    row_ra   = (state == S_PROC) ? p : idx[PIW-1:0];
    reach_ra = (state == S_E2 || state == S_E3) ? ep : idx[PIW-1:0];
    core_we = 1'b0;
    core_wd = '0;
    if (state == S_CORE && int'(nb_cnt) < int'(need)) begin
      core_we = 1'b1;
    end else if (state == S_KSEL && !ph && idx == point_count
                 && int'(acc_sum) >= int'(need)) begin
      core_we = 1'b1;
      core_wd = {1'b1, best};
    end
    dist_start = (state == S_DRD2);
  end

  odo_dist #(.COORD_WIDTH(COORD_WIDTH), .MAX_DIMS(MAX_DIMS), .DW(DW)) u_dist (
    .clk(clk), .rst(rst), .start(dist_start), .dims(dims_c),
    .a_row(prow), .b_row(row_rd), .done(dist_done), .dist_sq(dist_val)
  );

  // memory ports
  always_ff @(posedge clk) begin
    if (in_acc && int'(point_count) < MAX_POINTS) row_mem[point_count[PIW-1:0]] <= row_next;
    row_rd <= row_mem[row_ra];
    if (state == S_DWAIT && dist_done) dist_mem[idx[PIW-1:0]] <= dist_val;
    dist_rd <= dist_mem[idx[PIW-1:0]];
    if (state == S_UPD && ph && nb[idx[PIW-1:0]] && !processed[idx[PIW-1:0]]
        && (!rset[idx[PIW-1:0]] || reach_rd > nr)) begin
      reach_mem[idx[PIW-1:0]] <= nr;
      stamp_mem[idx[PIW-1:0]] <= stamp;
    end
    reach_rd <= reach_mem[reach_ra];
    stamp_rd <= stamp_mem[idx[PIW-1:0]];
    if (core_we) core_mem[p] <= core_wd;
    core_rd <= core_mem[ep];
    if (state == S_PROC) order_mem[order_len[PIW-1:0]] <= p;
    order_rd <= order_mem[k[PIW-1:0]];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      eps_sq     <= DIST_W'(1);
      min_points <= MINPTS_W'(2);
      num_dims   <= NDIMS_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EPS_SQ:     eps_sq     <= cfg_data[DIST_W-1:0];
        REG_MIN_POINTS: min_points <= cfg_data[MINPTS_W-1:0];
        REG_NUM_DIMS:   num_dims   <= cfg_data[NDIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      point_count   <= '0;
      coord_counter <= '0;
      dropped       <= 1'b0;
      out_ch.valid  <= 1'b0;
      processed     <= '0;
      rset          <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (int'(point_count) < MAX_POINTS) row_buf <= row_next;
            else dropped <= 1'b1;
            // the end word always restarts point grouping
            coord_counter <= (last_coord || in_ch.end_of_set) ? '0 : cc_eff + 1'b1;
            point_count   <= pc_next;
            if (in_ch.end_of_set) begin
              if (pc_next == '0) begin
                dropped       <= 1'b0;
              end else begin
                processed <= '0;
                rset      <= '0;
                stamp     <= '0;
                order_len <= '0;
                outer     <= '0;
                state     <= S_OUTER;
              end
            end
          end
        end
        S_OUTER: begin
          if (outer == point_count) begin
            k     <= '0;
            state <= S_E0;
          end else if (processed[outer[PIW-1:0]]) begin
            outer <= outer + 1'b1;
          end else begin
            p     <= outer[PIW-1:0];
            outer <= outer + 1'b1;
            state <= S_PROC;
          end
        end
        S_PROC: begin
          processed[p] <= 1'b1;
          order_len    <= order_len + 1'b1;
          state        <= S_PROW;
        end
        S_PROW: begin
          prow   <= row_rd;
          idx    <= '0;
          nb_cnt <= '0;
          state  <= S_DRD;
        end
        S_DRD: begin
          if (idx == point_count) begin
            state <= S_CORE;
          end else if (idx[PIW-1:0] == p) begin
            nb[p] <= 1'b0;
            idx   <= idx + 1'b1;
          end else begin
            state <= S_DRD2;
          end
        end
        S_DRD2: state <= S_DWAIT;
        S_DWAIT: begin
          if (dist_done) begin
            nb[idx[PIW-1:0]] <= (dist_val <= DW'(eps_sq));
            if (dist_val <= DW'(eps_sq)) nb_cnt <= nb_cnt + 1'b1;
            idx   <= idx + 1'b1;
            state <= S_DRD;
          end
        end
        S_CORE: begin
          idx      <= '0;
          ph       <= 1'b0;
          found    <= 1'b0;
          acc      <= '0;
          bcnt     <= '0;
          have_cur <= 1'b0;
          state    <= (int'(nb_cnt) < int'(need)) ? S_SEED : S_KSEL;
        end
        S_KSEL: begin
          // k-th smallest by repeated minimum extraction with multiplicity
          if (!ph) begin
            if (idx == point_count) begin
              idx   <= '0;
              found <= 1'b0;
              bcnt  <= '0;
              if (int'(acc_sum) >= int'(need)) begin
                core_val <= best;
                state    <= S_UPD;
              end else begin
                cur      <= best;
                have_cur <= 1'b1;
                acc      <= acc_sum;
              end
            end else begin
              ph <= 1'b1;
            end
          end else begin
            if (nb[idx[PIW-1:0]] && (!have_cur || dist_rd > cur)) begin
              if (!found || dist_rd < best) begin
                best  <= dist_rd;
                bcnt  <= PCW'(1);
                found <= 1'b1;
              end else if (dist_rd == best) begin
                bcnt <= bcnt + 1'b1;
              end
            end
            idx <= idx + 1'b1;
            ph  <= 1'b0;
          end
        end
        S_UPD: begin
          if (!ph) begin
            if (idx == point_count) begin
              idx   <= '0;
              found <= 1'b0;
              state <= S_SEED;
            end else begin
              ph <= 1'b1;
            end
          end else begin
            if (nb[idx[PIW-1:0]] && !processed[idx[PIW-1:0]]
                && (!rset[idx[PIW-1:0]] || reach_rd > nr)) begin
              rset[idx[PIW-1:0]] <= 1'b1;
              stamp              <= stamp + 1'b1;
            end
            idx <= idx + 1'b1;
            ph  <= 1'b0;
          end
        end
        S_SEED: begin
          // least reachability, ties to the latest stamp
          if (!ph) begin
            if (idx == point_count) begin
              if (found) begin
                p     <= bidx;
                state <= S_PROC;
              end else begin
                state <= S_OUTER;
              end
            end else begin
              ph <= 1'b1;
            end
          end else begin
            if (rset[idx[PIW-1:0]] && !processed[idx[PIW-1:0]]
                && (!found || reach_rd < br || (reach_rd == br && stamp_rd > bs))) begin
              found <= 1'b1;
              br    <= reach_rd;
              bs    <= stamp_rd;
              bidx  <= idx[PIW-1:0];
            end
            idx <= idx + 1'b1;
            ph  <= 1'b0;
          end
        end
        S_E0: state <= S_E1;
        S_E1: begin
          ep    <= order_rd;
          state <= S_E2;
        end
        S_E2: state <= S_E3;
        S_E3: begin
          out_ch.point_index    <= IDX_W'(ep);
          out_ch.core_finite    <= core_rd[DW];
          out_ch.core_dist_sq   <= core_rd[DW] ? core_rd[DIST_W-1:0] : '0;
          out_ch.reach_finite   <= rset[ep];
          out_ch.reach_dist_sq  <= rset[ep] ? reach_rd[DIST_W-1:0] : '0;
          out_ch.points_dropped <= dropped;
          out_ch.last           <= (k + 1'b1 == order_len);
          out_ch.valid          <= 1'b1;
          state                 <= S_E4;
        end
        S_E4: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            if (k + 1'b1 == order_len) begin
              point_count   <= '0;
              coord_counter <= '0;
              dropped       <= 1'b0;
              state         <= S_LOAD;
            end else begin
              k     <= k + 1'b1;
              state <= S_E0;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input open while result pending");
  a_order_bound: assert property (@(posedge clk) disable iff (rst)
    order_len <= point_count || state == S_LOAD) else $error("order longer than set");
  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
    else $error("no return to loading after last word");
  a_valid_only_emit: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> state == S_E4) else $error("result valid outside emit");
endmodule
`default_nettype wire
